// ----- src/umds_pkg.sv -----
// Shared types and constants for the upstream motif distance scan.
// No dependencies; imported by every module of the block.
package umds_pkg;

	typedef logic [7:0] byte_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} umds_state_t;

	// Configuration register indexes
	localparam logic [1:0] REG_MOTIF_WORD = 2'd0;
	localparam logic [1:0] REG_FAR_GAP    = 2'd1;
	localparam logic [1:0] REG_NEAR_GAP   = 2'd2;
	localparam logic [1:0] REG_TARGET_GAP = 2'd3;

	// Register reset values
	localparam logic [31:0] MOTIF_WORD_RST = 32'h7461_7461;
	localparam logic [6:0]  FAR_GAP_RST    = 7'd40;
	localparam logic [5:0]  NEAR_GAP_RST   = 6'd20;
	localparam logic [6:0]  TARGET_GAP_RST = 7'd30;

	// Distance reported when no motif qualifies
	localparam byte_t NO_MATCH = 8'hFF;

	typedef struct packed {
		logic clear;  // new item: restart the best-distance search
		logic step;   // evaluate the distance now at the window
	} umds_pick_ctl_t;

endpackage

// ----- src/umds_cell.sv -----
// One history cell: holds a single base and takes its neighbor's base when enabled.
// Depends on umds_pkg.
module umds_cell
	import umds_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  byte_t d_in,
	output byte_t q
);

	byte_t base_q;

	always_ff @(posedge clk) begin
		if (en) begin
			base_q <= d_in;
		end
	end

	assign q = base_q;

endmodule

// ----- src/umds_pick.sv -----
// Best-distance tracker: matches the four window cells against the motif and keeps
// the distance closest to the target gap, farther start winning ties. Depends on umds_pkg.
module umds_pick
	import umds_pkg::*;
#(
	parameter int DW = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	input  umds_pick_ctl_t  ctl,
	input  logic [DW-1:0]   scan_d,
	input  logic [3:0][7:0] win,
	input  logic [31:0]     motif_word,
	input  logic [5:0]      near_gap,
	input  logic [DW-1:0]   top,
	input  logic [6:0]      target_gap,
	output byte_t           best
);

	localparam int CW = ((DW > 7) ? DW : 7) + 1;

	byte_t         best_q;
	logic [CW-1:0] best_err_q;
	logic [CW-1:0] d_ext;
	logic [CW-1:0] t_ext;
	logic [CW-1:0] err;
	logic          match;
	logic          in_window;
	logic          take;

	always_comb begin
		d_ext = CW'(scan_d);
		t_ext = CW'(target_gap);
		err   = (t_ext >= d_ext) ? (t_ext - d_ext) : (d_ext - t_ext);
		match = 1'b1;
		// motif bytes past the current base never match
		for (int j = 0; j < 4; j++) begin
			if ((win[j] != motif_word[31-8*j -: 8]) || (d_ext < CW'(j))) begin
				match = 1'b0;
			end
		end
		in_window = (d_ext > CW'(near_gap)) && (d_ext <= CW'(top));
		take      = ctl.step && match && in_window && (err < best_err_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q     <= NO_MATCH;
			best_err_q <= '0;
		end else if (ctl.clear) begin
			best_q     <= NO_MATCH;
			best_err_q <= t_ext + CW'(1);  // distance to "none" (-1)
		end else if (take) begin
			best_q     <= 8'(scan_d);
			best_err_q <= err;
		end
	end

	assign best = best_q;

endmodule

// ----- src/upstream_motif_distance_scan.sv -----
// Top level of the upstream motif distance scan: controller, history ring of cells,
// configuration registers and output register. Depends on umds_pkg, umds_cell, umds_pick.
//
// Takes one base per input item (tdata = base_byte, tuser = sequence_start) and returns
// one signed distance per item: the lookback to a motif start within (near_gap, far_gap],
// closest to target_gap, farther start on a tie, or -1. The last MAX_LOOKBACK+1 bases sit
// in a ring of cells; per item the ring rotates once all the way round past a four-cell
// window, one distance per cycle, before the next item is accepted. One item is worked
// on at a time; a finished result waits in the output register while the next item is
// taken. Configuration is to be written through the cfg port only while no item is in
// flight; the block itself does not enforce this. The cfg port is always ready.
module upstream_motif_distance_scan
	import umds_pkg::*;
#(
	parameter int MAX_LOOKBACK = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// input item
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] base_byte
	input  logic [0:0]  s_tuser,   // [0] sequence_start
	// result item
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] motif_distance (signed)
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_addr,
	input  logic [31:0] cfg_data
);

	localparam int L  = MAX_LOOKBACK + 1;
	localparam int DW = $clog2(MAX_LOOKBACK + 1);
	localparam int CW = ((DW > 7) ? DW : 7) + 1;

	umds_state_t    state_q, state_nxt;
	logic [31:0]    motif_word_q;
	logic [6:0]     far_gap_q;
	logic [5:0]     near_gap_q;
	logic [6:0]     target_gap_q;
	logic [DW-1:0]  pc_q;
	logic [DW-1:0]  pc_eff;
	logic [DW-1:0]  top_q;
	logic [DW-1:0]  dist_q;
	logic [CW-1:0]  lim;
	byte_t          out_q;
	logic           out_valid_q;
	logic           accept;
	logic           scan_en;
	logic           out_free;
	logic           out_load;
	logic           cell_en;
	byte_t          cell_q  [L];
	byte_t          chain_in[L];
	logic [3:0][7:0] win;
	umds_pick_ctl_t pick_ctl;
	byte_t          best;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motif_word_q <= MOTIF_WORD_RST;
			far_gap_q    <= FAR_GAP_RST;
			near_gap_q   <= NEAR_GAP_RST;
			target_gap_q <= TARGET_GAP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_addr)
				REG_MOTIF_WORD: motif_word_q <= cfg_data;
				REG_FAR_GAP:    far_gap_q    <= cfg_data[6:0];
				REG_NEAR_GAP:   near_gap_q   <= cfg_data[5:0];
				REG_TARGET_GAP: target_gap_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// controller
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_nxt = ST_SCAN;
			ST_SCAN: if (dist_q == '0) state_nxt = ST_DONE;
			ST_DONE: if (out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		s_tready = 1'b0;
		scan_en  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_SCAN: scan_en  = 1'b1;
			ST_DONE: out_load = out_free;
			default: ;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// position and window top, fixed at accept
	assign pc_eff = s_tuser[0] ? '0 : pc_q;

	always_comb begin
		lim = CW'(far_gap_q);
		if (lim > CW'(MAX_LOOKBACK)) lim = CW'(MAX_LOOKBACK);
		if (lim > CW'(pc_eff))       lim = CW'(pc_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			top_q  <= '0;
			dist_q <= '0;
		end else if (accept) begin
			pc_q   <= (pc_eff == DW'(MAX_LOOKBACK)) ? pc_eff : pc_eff + DW'(1);
			top_q  <= DW'(lim);
			dist_q <= DW'(MAX_LOOKBACK);
		end else if (scan_en && (dist_q != '0)) begin
			dist_q <= dist_q - DW'(1);
		end
	end

	// history ring: shift in the new base on accept, rotate once round during the scan
	assign cell_en = accept || scan_en;

	always_comb begin
		chain_in[0] = scan_en ? cell_q[L-1] : s_tdata;
		for (int k = 1; k < L; k++) begin
			chain_in[k] = cell_q[k-1];
		end
	end

	for (genvar k = 0; k < L; k++) begin : g_cell
		umds_cell u_cell (
			.clk  (clk),
			.en   (cell_en),
			.d_in (chain_in[k]),
			.q    (cell_q[k])
		);
	end

	// window at the far end shows bases at dist_q .. dist_q-3
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			win[j] = cell_q[MAX_LOOKBACK-j];
		end
	end

	assign pick_ctl.clear = accept;
	assign pick_ctl.step  = scan_en;

	umds_pick #(
		.DW (DW)
	) u_pick (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (pick_ctl),
		.scan_d     (dist_q),
		.win        (win),
		.motif_word (motif_word_q),
		.near_gap   (near_gap_q),
		.top        (top_q),
		.target_gap (target_gap_q),
		.best       (best)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= NO_MATCH;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			out_q       <= best;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

`ifndef SYNTH
	a_result_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result item raised without a finished scan");

	a_scan_starts_full: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (dist_q == DW'(MAX_LOOKBACK)) && (state_q == ST_SCAN))
		else $error("scan did not start at the far end of the ring");

	a_scan_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_en && (dist_q != '0)) |=> (dist_q == $past(dist_q) - DW'(1)))
		else $error("scan distance skipped");

	a_no_zero_distance: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata != 8'h00))
		else $error("distance zero reported");
`endif

endmodule

// ----- tb/tb_upstream_motif_distance_scan.sv -----
`timescale 1ns / 1ps
// Self-checking bench for upstream_motif_distance_scan: a table of directed bases, then random
// sequences over several register settings; typed rows are checked against their want field,
// the rest against a local scan model. Depends on umds_pkg and upstream_motif_distance_scan.
module tb_upstream_motif_distance_scan;
	import umds_pkg::*;

	localparam int LOOKBACK    = 64;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES      = 8;
	localparam int PHASE_BASES = 90;
	localparam int RETUNE_ROW  = 3;
	localparam int PROBES      = 23;

	localparam byte_t CH_T = "t";
	localparam byte_t CH_A = "a";
	localparam byte_t CH_X = "x";

	typedef struct packed {
		byte_t base;
		logic  first;
		logic  typed;  // want is read straight off the table
		byte_t want;
	} probe_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_addr = '0;
	logic [31:0] cfg_data = '0;

	// scan model state
	bit [7:0]    hist [LOOKBACK];
	int          head;
	int          pos;
	logic [31:0] motif_r = MOTIF_WORD_RST;
	logic [6:0]  far_r = FAR_GAP_RST;
	logic [5:0]  near_r = NEAR_GAP_RST;
	logic [6:0]  target_r = TARGET_GAP_RST;

	byte_t  distance_q [$];
	probe_t probes [PROBES];
	bit     calm = 1'b0;
	int     errors;
	int     bases_sent;
	int     seqs;
	int     settings;
	int     results_seen;
	int     hits;
	int     stall;

	upstream_motif_distance_scan #(.MAX_LOOKBACK(LOOKBACK)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int gap_dist(input int a, input int b);
		return (a > b) ? a - b : b - a;
	endfunction

	// Distance to the motif start closest to the target gap; scans far to near,
	// so on a tie the farther start stays. Advances the history afterwards.
	function automatic byte_t nearest_motif_distance(input byte_t b, input logic first);
		int    top;
		int    best;
		int    d;
		int    k;
		int    back;
		int    lo;
		int    tgt;
		bit    hit;
		byte_t v;
		if (first)
			pos = 0;
		top = far_r;
		if (top > LOOKBACK)
			top = LOOKBACK;
		if (top > pos)
			top = pos;
		lo = near_r;
		tgt = target_r;
		best = -1;
		for (d = top; d > lo; d--) begin
			hit = 1'b1;
			for (k = 0; k < 4; k++) begin
				back = d - k;
				if (back < 0) begin
					hit = 1'b0;
				end else begin
					v = (back == 0) ? b : hist[(head + LOOKBACK - back) % LOOKBACK];
					if (v != motif_r[31 - 8 * k -: 8])
						hit = 1'b0;
				end
			end
			if (hit && gap_dist(tgt, d) < gap_dist(tgt, best))
				best = d;
		end
		hist[head] = b;
		head = (head + 1) % LOOKBACK;
		if (pos < LOOKBACK)
			pos++;
		return best[7:0];
	endfunction

	task automatic feed_base(input byte_t b, input logic first, input logic typed,
			input byte_t want);
		int    gap;
		byte_t got;
		gap = 0;
		if (!calm && $urandom_range(99) < 16)
			gap = $urandom_range(4, 1);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= first;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		got = nearest_motif_distance(b, first);
		distance_q = {distance_q, (typed ? want : got)};
		bases_sent++;
	endtask

	task automatic wait_drained(input int tail);
		while (distance_q.size() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_regs(input logic [31:0] mw, input int fg, input int ng, input int tg);
		logic [1:0]  idx [4] = '{REG_MOTIF_WORD, REG_FAR_GAP, REG_NEAR_GAP, REG_TARGET_GAP};
		logic [31:0] vals [4];
		int          r;
		vals = '{mw, fg, ng, tg};
		s_tvalid <= 1'b0;
		wait_drained(4);
		for (r = 0; r < 4; r++) begin
			cfg_valid <= 1'b1;
			cfg_addr <= idx[r];
			cfg_data <= vals[r];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			case (idx[r])
				REG_MOTIF_WORD: motif_r = vals[r];
				REG_FAR_GAP:    far_r = vals[r][6:0];
				REG_NEAR_GAP:   near_r = vals[r][5:0];
				REG_TARGET_GAP: target_r = vals[r][6:0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
		settings++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= calm || ($urandom_range(99) >= 16);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (m_tdata != NO_MATCH)
				hits++;
			if (distance_q.size() == 0) begin
				$error("motif_distance: result %0d with no item waiting", $signed(m_tdata));
				errors++;
			end else if (m_tdata !== distance_q[0]) begin
				$error("motif_distance: expected %0d, got %0d",
					$signed(distance_q[0]), $signed(m_tdata));
				errors++;
				void'(distance_q.pop_front());
			end else begin
				void'(distance_q.pop_front());
			end
		end
	end

	// no accept on any channel for too long means the block hung
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				stall <= 0;
			else
				stall <= stall + 1;
			if (stall >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		int          i;
		int          ph;
		int          sent;
		int          len;
		int          n;
		int          plant;
		int          fg;
		int          ng;
		int          tg;
		bit          fresh;
		byte_t       b;
		logic [31:0] mw;

		// rows 0-2 run at reset settings with no start flag: too few bases, no match.
		// Then far 8 / near 4 / target 6: a lone motif at the head, and a tie case.
		probes = '{
			'{8'h00, 1'b0, 1'b1, NO_MATCH},
			'{8'hFF, 1'b0, 1'b1, NO_MATCH},
			'{CH_T,  1'b0, 1'b1, NO_MATCH},
			'{CH_T,  1'b1, 1'b1, NO_MATCH},
			'{CH_A,  1'b0, 1'b1, NO_MATCH},
			'{CH_T,  1'b0, 1'b1, NO_MATCH},
			'{CH_A,  1'b0, 1'b1, NO_MATCH},
			'{8'h00, 1'b0, 1'b1, NO_MATCH},
			'{8'hFF, 1'b0, 1'b1, 8'd5},
			'{8'h00, 1'b0, 1'b1, 8'd6},
			'{8'hFF, 1'b0, 1'b1, 8'd7},
			'{8'h00, 1'b0, 1'b1, 8'd8},
			'{8'hFF, 1'b0, 1'b1, NO_MATCH},
			'{CH_T,  1'b1, 1'b0, 8'h00},
			'{CH_A,  1'b0, 1'b0, 8'h00},
			'{CH_T,  1'b0, 1'b0, 8'h00},
			'{CH_A,  1'b0, 1'b0, 8'h00},
			'{CH_T,  1'b0, 1'b0, 8'h00},
			'{CH_A,  1'b0, 1'b0, 8'h00},
			'{CH_X,  1'b0, 1'b0, 8'h00},
			'{CH_X,  1'b0, 1'b0, 8'h00},
			'{CH_X,  1'b0, 1'b0, 8'h00},
			'{CH_X,  1'b0, 1'b0, 8'h00}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < PROBES; i++) begin
			if (i == RETUNE_ROW)
				write_regs(MOTIF_WORD_RST, 8, 4, 6);
			if (probes[i].first)
				seqs++;
			feed_base(probes[i].base, probes[i].first, probes[i].typed, probes[i].want);
		end

		for (ph = 0; ph < PHASES; ph++) begin
			mw = $urandom();
			fg = $urandom_range(64, 4);
			ng = ($urandom_range(9) == 0) ? $urandom_range(63, 3) : $urandom_range(fg - 1, 3);
			tg = $urandom_range(64, 0);
			case (ph)
				0: begin
					fg = 64; ng = 3; tg = 0;
				end
				1: begin
					fg = 4; ng = 63; tg = 64;  // empty window throughout
				end
				2: begin
					mw = MOTIF_WORD_RST; fg = 64; ng = 63; tg = 64;
				end
				3: begin
					fg = 4; ng = 3; tg = 4;
				end
				4: begin
					mw = MOTIF_WORD_RST; fg = FAR_GAP_RST; ng = NEAR_GAP_RST; tg = TARGET_GAP_RST;
				end
				5: mw = 32'h0000_0000;
				6: mw = 32'hFFFF_FFFF;
				default: ;
			endcase
			write_regs(mw, fg, ng, tg);
			calm = (ph == 4);
			sent = 0;
			while (sent < PHASE_BASES) begin
				n = $urandom_range(99);
				if (n < 25)
					len = $urandom_range(100, 60);
				else if (n < 75)
					len = $urandom_range(40, 5);
				else
					len = $urandom_range(4, 1);
				// keep each phase to its share of bases
				if (len > PHASE_BASES - sent)
					len = PHASE_BASES - sent;
				// now and then a sequence runs on without its start flag
				fresh = ($urandom_range(9) != 0);
				if (fresh)
					seqs++;
				plant = 0;
				for (n = 0; n < len; n++) begin
					if (plant == 0 && $urandom_range(99) < 12)
						plant = 4;
					if (plant > 0) begin
						b = mw[8 * plant - 1 -: 8];
						plant--;
					end else if ($urandom_range(99) < 60) begin
						b = mw[8 * $urandom_range(3, 0) +: 8];
					end else begin
						b = $urandom_range(255, 0);
					end
					feed_base(b, fresh && n == 0, 1'b0, 8'h00);
				end
				sent += len;
			end
			calm = 1'b0;
		end

		s_tvalid <= 1'b0;
		wait_drained(LOOKBACK + 8);

		$display("Sent %0d bases in %0d flagged sequences under %0d register settings.",
			bases_sent, seqs, settings);
		$display("Checked %0d distances, %0d of them pointing at a motif.", results_seen, hits);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/umds_pkg.sv
src/umds_cell.sv
src/umds_pick.sv
src/upstream_motif_distance_scan.sv
tb/tb_upstream_motif_distance_scan.sv
